// ----- sv/rgbhsl_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// shared types, constants and the divider step for the rgb to hsl converter
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsl_pkg;

   // quotient widths of the two dividers
   localparam int SAT_BITS   = 16;
   localparam int HUE_BITS   = 10;

   // divider stages and quotient bits resolved per stage
   localparam int DIV_STAGES = 4;
   localparam int SAT_PER    = (SAT_BITS + DIV_STAGES - 1) / DIV_STAGES;
   localparam int HUE_PER    = (HUE_BITS + DIV_STAGES - 1) / DIV_STAGES;

   // prep, multiply, divider stages, output register
   localparam int NUM_STAGES = DIV_STAGES + 3;

   // hue scale in sixteenths of a degree
   localparam int HUE_SCALE  = 960;
   localparam int OFFSET_GRN = 1920;
   localparam int OFFSET_BLU = 3840;
   localparam int HUE_FULL   = 5760;

   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic [7:0] delta;
      logic [7:0] den;
      logic [8:0] sum;
      logic       gray;
      logic       neg;
      sector_type sector;
      logic [7:0] dabs;
   } prep_type;

   typedef struct packed {
      logic [7:0]          delta;
      logic [7:0]          den;
      logic [8:0]          sum;
      logic                gray;
      logic                neg;
      sector_type          sector;
      logic [7:0]          sat_rem;
      logic [SAT_BITS-1:0] sat_qd;
      logic [7:0]          hue_rem;
      logic [HUE_BITS-1:0] hue_qd;
   } work_type;

   // one restoring step: shift in a dividend bit, return {quotient bit, remainder}
   function automatic logic [8:0] div_step(input logic [7:0] rem,
                                           input logic       dbit,
                                           input logic [7:0] divisor);
      logic [8:0] t;
      logic [8:0] d;
      t = {rem, dbit};
      d = {1'b0, divisor};
      if (t >= d) begin
         div_step = {1'b1, 8'(t - d)};
      end else begin
         div_step = {1'b0, t[7:0]};
      end
   endfunction

endpackage

`default_nettype wire

// ----- sv/rgb_to_hsl_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// pipelined conversion of one 8-bit rgb pixel to hue, saturation, lightness
// ----------------------------------------------------------------------------
// pipeline: an accepted item passes the prep, multiply, divider and output registers
//   in that order before rsp_valid rises
// throughput: one item per cycle while rsp_ready keeps the output moving; the four
//   restoring divider stages (4 saturation bits and up to 3 hue bits each) set the stage depth
// reset: synchronous, clears every stage valid bit and rsp_valid
`default_nettype none

module rgb_to_hsl_converter
   import rgbhsl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [12:0]      rsp_hue_sixteenths,
   output logic [15:0]      rsp_saturation_q15,
   output logic [8:0]       rsp_lightness_sum
);

   // stage valid bits, the top one is the output register
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] advance;

   prep_type prep_ff, prep_in;
   work_type mul_ff, mul_in;
   work_type div_ff  [DIV_STAGES];
   work_type div_in  [DIV_STAGES];
   work_type div_src [DIV_STAGES];

   logic [12:0] hue_ff, hue_in;
   logic [15:0] sat_ff, sat_in;
   logic [8:0]  sum_ff;

   // a stage loads when it is empty or its item moves on
   always_comb begin
      advance[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   always_comb begin
      valid_in[0] = req_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   assign req_ready = advance[0];

   // ---------------------------------------------------------------- prep
   // max, min, sector precedence red then green then blue, signed difference
   always_comb begin
      logic [7:0] mx;
      logic [7:0] mn;
      logic [7:0] pa;
      logic [7:0] pb;
      logic [8:0] sum;
      mx = req_red;
      mn = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx)  mx = req_blue;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn)  mn = req_blue;
      sum = {1'b0, mx} + {1'b0, mn};

      if (req_red == mx) begin
         prep_in.sector = SECT_RED;
         pa = req_green;
         pb = req_blue;
      end else if (req_green == mx) begin
         prep_in.sector = SECT_GREEN;
         pa = req_blue;
         pb = req_red;
      end else begin
         prep_in.sector = SECT_BLUE;
         pa = req_red;
         pb = req_green;
      end

      prep_in.delta = mx - mn;
      prep_in.sum   = sum;
      // saturation divisor folds at the midpoint of lightness
      prep_in.den   = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
      prep_in.gray  = (mx == mn);
      prep_in.neg   = (pa < pb);
      prep_in.dabs  = (pa < pb) ? (pb - pa) : (pa - pb);
   end

   // ---------------------------------------------------------------- multiply
   // hue numerator 960*|diff| stays below 1024*delta, so its top bits seed the
   // remainder; saturation numerator is delta << 15 with delta <= den
   always_comb begin
      logic [17:0] num;
      num            = 18'(prep_ff.dabs) * 18'(HUE_SCALE);
      mul_in.delta   = prep_ff.delta;
      mul_in.den     = prep_ff.den;
      mul_in.sum     = prep_ff.sum;
      mul_in.gray    = prep_ff.gray;
      mul_in.neg     = prep_ff.neg;
      mul_in.sector  = prep_ff.sector;
      mul_in.hue_rem = num[17:HUE_BITS];
      mul_in.hue_qd  = num[HUE_BITS-1:0];
      mul_in.sat_rem = {1'b0, prep_ff.delta[7:1]};
      mul_in.sat_qd  = {prep_ff.delta[0], {(SAT_BITS-1){1'b0}}};
   end

   // ---------------------------------------------------------------- divide
   // dividend bits leave the top of each qd register, quotient bits enter below
   assign div_src[0] = mul_ff;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      if (s > 0) begin : g_link
         assign div_src[s] = div_ff[s-1];
      end

      always_comb begin
         work_type   w;
         logic [8:0] res;
         w = div_src[s];
         for (int j = 0; j < SAT_PER; j++) begin
            if (s * SAT_PER + j < SAT_BITS) begin
               res       = div_step(w.sat_rem, w.sat_qd[SAT_BITS-1], w.den);
               w.sat_qd  = {w.sat_qd[SAT_BITS-2:0], res[8]};
               w.sat_rem = res[7:0];
            end
         end
         for (int j = 0; j < HUE_PER; j++) begin
            if (s * HUE_PER + j < HUE_BITS) begin
               res       = div_step(w.hue_rem, w.hue_qd[HUE_BITS-1], w.delta);
               w.hue_qd  = {w.hue_qd[HUE_BITS-2:0], res[8]};
               w.hue_rem = res[7:0];
            end
         end
         div_in[s] = w;
      end
   end

   // ---------------------------------------------------------------- output
   // quotient magnitude is applied with the sign of the difference, which
   // gives truncation toward zero; only the red sector can wrap below zero
   always_comb begin
      work_type    w;
      logic [12:0] q;
      w = div_ff[DIV_STAGES-1];
      q = 13'(w.hue_qd);
      case (w.sector)
         SECT_RED: begin
            hue_in = (w.neg && (q != 13'd0)) ? (13'(HUE_FULL) - q) : q;
         end
         SECT_GREEN: begin
            hue_in = w.neg ? (13'(OFFSET_GRN) - q) : (13'(OFFSET_GRN) + q);
         end
         SECT_BLUE: begin
            hue_in = w.neg ? (13'(OFFSET_BLU) - q) : (13'(OFFSET_BLU) + q);
         end
         default: begin
            hue_in = 13'd0;
         end
      endcase
      sat_in = w.sat_qd;
      // gray pixels have a zero divisor somewhere, force both to zero
      if (w.gray) begin
         hue_in = 13'd0;
         sat_in = 16'd0;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (advance[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         prep_ff <= prep_in;
      end
      if (advance[1]) begin
         mul_ff <= mul_in;
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (advance[s+2]) begin
            div_ff[s] <= div_in[s];
         end
      end
      if (advance[NUM_STAGES-1]) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         sum_ff <= div_ff[DIV_STAGES-1].sum;
      end
   end

   assign rsp_valid          = valid_ff[NUM_STAGES-1];
   assign rsp_hue_sixteenths = hue_ff;
   assign rsp_saturation_q15 = sat_ff;
   assign rsp_lightness_sum  = sum_ff;

`ifndef SYNTHESIS
   // hue stays inside one full turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue_sixteenths < 13'(HUE_FULL)))
      else $error("hue out of range");

   // saturation is zero only for gray, and gray has zero hue
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_saturation_q15 == 16'd0)) |-> (rsp_hue_sixteenths == 13'd0))
      else $error("zero saturation with nonzero hue");

   // saturation never exceeds one
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_saturation_q15 <= 16'd32768))
      else $error("saturation above one");

   // an item entering an empty pipeline reaches the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (valid_ff == '0)) |-> ##7 rsp_valid)
      else $error("item lost in pipeline");
`endif

endmodule

`default_nettype wire
